/* design/tlvv_pkg.sv */
// Shared types, codes and the fixed key table of the settings image validator.
package tlvv_pkg;

	localparam int KEY_TOTAL = 32;
	localparam int KEY_W     = $clog2(KEY_TOTAL);
	localparam int DEFAULT_IMAGE_CAPACITY = 8192;

	typedef enum logic [1:0] {
		PH_KEY     = 2'd0,
		PH_SIZE_LO = 2'd1,
		PH_SIZE_HI = 2'd2,
		PH_VALUE   = 2'd3
	} phase_t;

	typedef enum logic [3:0] {
		ERR_OK        = 4'd0,
		ERR_TOO_LONG  = 4'd1,
		ERR_CUT_HDR   = 4'd2,
		ERR_BAD_ID    = 4'd3,
		ERR_REPEAT    = 4'd4,
		ERR_ZERO_SIZE = 4'd5,
		ERR_TOO_BIG   = 4'd6,
		ERR_CUT_VALUE = 4'd7,
		ERR_KIND_SIZE = 4'd8,
		ERR_TEXT      = 4'd9,
		ERR_COLOUR    = 4'd10,
		ERR_FLOAT     = 4'd11,
		ERR_RANGE     = 4'd12
	} err_t;

	typedef enum logic [2:0] {
		K_BLOB  = 3'd0,
		K_BYTE  = 3'd1,
		K_UINT  = 3'd2,
		K_FLOAT = 3'd3,
		K_TEXT  = 3'd4
	} kind_t;

	localparam logic [31:0] COLOUR_MAX = 32'h00FF_FFFF;

	localparam kind_t KEY_KIND [0:KEY_TOTAL-1] = '{
		K_BLOB, K_BYTE, K_UINT, K_UINT, K_UINT, K_BYTE, K_BYTE, K_BYTE,
		K_BYTE, K_BYTE, K_UINT, K_UINT, K_BYTE, K_BYTE, K_FLOAT, K_FLOAT,
		K_BYTE, K_BYTE, K_BYTE, K_BYTE, K_BYTE, K_UINT, K_UINT, K_BYTE,
		K_BYTE, K_BYTE, K_BYTE, K_BLOB, K_TEXT, K_TEXT, K_BYTE, K_BYTE};

	localparam logic [15:0] KEY_MAX [0:KEY_TOTAL-1] = '{
		16'd4096, 16'd1, 16'd4, 16'd4, 16'd4, 16'd1, 16'd1, 16'd1,
		16'd1, 16'd1, 16'd4, 16'd4, 16'd1, 16'd1, 16'd4, 16'd4,
		16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd4, 16'd4, 16'd1,
		16'd1, 16'd1, 16'd1, 16'd56, 16'd33, 16'd33, 16'd1, 16'd1};

	localparam logic [7:0] BYTE_LOW [0:KEY_TOTAL-1] = '{
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd5, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1,
		8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};

	localparam logic [7:0] BYTE_HIGH [0:KEY_TOTAL-1] = '{
		8'd1, 8'd2, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
		8'd1, 8'd5, 8'd1, 8'd1, 8'd50, 8'd4, 8'd1, 8'd1,
		8'd4, 8'd4, 8'd1, 8'd1, 8'd50, 8'd1, 8'd1, 8'd4,
		8'd4, 8'd1, 8'd2, 8'd1, 8'd1, 8'd1, 8'd1, 8'd13};

	// Per-image parser state; the byte count lives outside because its width follows
	// the image capacity.
	typedef struct packed {
		phase_t                 phase;
		logic [7:0]             key;
		logic [15:0]            size;
		logic [15:0]            left;
		logic [2:0]             idx;
		logic [31:0]            value_word;
		logic [KEY_TOTAL-1:0]   seen;
		err_t                   err;
	} st_t;

	localparam st_t ST_CLEAR = '{
		phase:      PH_KEY,
		key:        8'd0,
		size:       16'd0,
		left:       16'd0,
		idx:        3'd0,
		value_word: 32'd0,
		seen:       '0,
		err:        ERR_OK};

endpackage

/* design/tlvv_in_if.sv */
// Input channel: one image byte per word, with end-of-image marks.
interface tlvv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       empty_image;

	modport source(output valid, data_byte, last_byte, empty_image, input ready);
	modport sink(input valid, data_byte, last_byte, empty_image, output ready);
endinterface

/* design/tlvv_out_if.sv */
// Output channel: one verdict word per image.
interface tlvv_out_if;
	logic       valid;
	logic       ready;
	logic       image_valid;
	logic [3:0] error_code;

	modport source(output valid, image_valid, error_code, input ready);
	modport sink(input valid, image_valid, error_code, output ready);
endinterface

/* design/tlvv_step.sv */
// Next-state and verdict logic for one accepted input word.
module tlvv_step #(
	parameter int IMAGE_CAPACITY = tlvv_pkg::DEFAULT_IMAGE_CAPACITY,
	parameter int CNT_W = $clog2(IMAGE_CAPACITY + 2)
) (
	input  tlvv_pkg::st_t st_q,
	input  logic [CNT_W-1:0] cnt_q,
	input  logic [7:0] data_byte,
	input  logic empty_image,
	output tlvv_pkg::st_t st_n,
	output logic [CNT_W-1:0] cnt_n,
	output tlvv_pkg::err_t code
);
	import tlvv_pkg::*;

	localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(IMAGE_CAPACITY + 1);
	localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(IMAGE_CAPACITY);

	logic [KEY_W-1:0] key_lo;
	kind_t            kind;
	logic [15:0]      size_full;
	logic [15:0]      left_dec;
	logic [31:0]      vw;
	err_t             hdr_err;
	err_t             val_err;

	assign key_lo    = st_q.key[KEY_W-1:0];
	assign kind      = KEY_KIND[key_lo];
	assign size_full = {data_byte, st_q.size[7:0]};
	assign left_dec  = st_q.left - 16'd1;

	always_comb begin
		if (st_q.key[7:KEY_W] != '0) begin
			hdr_err = ERR_BAD_ID;
		end else if (st_q.seen[key_lo]) begin
			hdr_err = ERR_REPEAT;
		end else if (size_full == 16'd0) begin
			hdr_err = ERR_ZERO_SIZE;
		end else if (size_full > KEY_MAX[key_lo]) begin
			hdr_err = ERR_TOO_BIG;
		end else begin
			hdr_err = ERR_OK;
		end
	end

	// Value bytes are gathered little-endian; a text value only records an inner NUL.
	always_comb begin
		vw = st_q.value_word;
		if ((kind == K_UINT || kind == K_FLOAT) && !st_q.idx[2]) begin
			vw = st_q.value_word | (32'(data_byte) << {st_q.idx[1:0], 3'b000});
		end else if (kind == K_BYTE && st_q.idx == 3'd0) begin
			vw = {24'd0, data_byte};
		end else if (kind == K_TEXT && st_q.left > 16'd1 && data_byte == 8'd0) begin
			vw = 32'd1;
		end
	end

	always_comb begin
		if (kind == K_BYTE && st_q.size != 16'd1) begin
			val_err = ERR_KIND_SIZE;
		end else if ((kind == K_UINT || kind == K_FLOAT) && st_q.size != 16'd4) begin
			val_err = ERR_KIND_SIZE;
		end else if (kind == K_TEXT && (data_byte != 8'd0 || vw != 32'd0)) begin
			val_err = ERR_TEXT;
		end else if (kind == K_UINT && vw > COLOUR_MAX) begin
			val_err = ERR_COLOUR;
		end else if (kind == K_FLOAT && vw[30:23] == 8'hFF) begin
			val_err = ERR_FLOAT;
		end else if (kind == K_BYTE &&
				(vw[7:0] < BYTE_LOW[key_lo] || vw[7:0] > BYTE_HIGH[key_lo])) begin
			val_err = ERR_RANGE;
		end else begin
			val_err = ERR_OK;
		end
	end

	always_comb begin
		st_n  = st_q;
		cnt_n = cnt_q;
		if (!empty_image) begin
			if (cnt_q != CNT_SAT) begin
				cnt_n = cnt_q + 1'b1;
			end
			if (st_q.err == ERR_OK) begin
				case (st_q.phase)
					PH_KEY: begin
						st_n.key   = data_byte;
						st_n.phase = PH_SIZE_LO;
					end
					PH_SIZE_LO: begin
						st_n.size  = {8'd0, data_byte};
						st_n.phase = PH_SIZE_HI;
					end
					PH_SIZE_HI: begin
						st_n.size = size_full;
						if (hdr_err != ERR_OK) begin
							st_n.err = hdr_err;
						end else begin
							st_n.seen[key_lo] = 1'b1;
							st_n.left         = size_full;
							st_n.value_word   = 32'd0;
							st_n.idx          = 3'd0;
							st_n.phase        = PH_VALUE;
						end
					end
					PH_VALUE: begin
						st_n.value_word = vw;
						st_n.left       = left_dec;
						if (!st_q.idx[2]) begin
							st_n.idx = st_q.idx + 3'd1;
						end
						if (left_dec == 16'd0) begin
							st_n.err   = val_err;
							st_n.phase = PH_KEY;
						end
					end
					default: st_n.phase = PH_KEY;
				endcase
			end
		end
	end

	always_comb begin
		if (cnt_n > CNT_CAP) begin
			code = ERR_TOO_LONG;
		end else if (st_n.err != ERR_OK) begin
			code = st_n.err;
		end else if (st_n.phase == PH_SIZE_LO || st_n.phase == PH_SIZE_HI) begin
			code = ERR_CUT_HDR;
		end else if (st_n.phase == PH_VALUE) begin
			code = ERR_CUT_VALUE;
		end else begin
			code = ERR_OK;
		end
	end

endmodule

/* design/tlv_settings_image_validator_unit.sv */
// Settings image validator: checks a key/size/value image byte by byte, one verdict per image.
// The verdict is registered and shown in the cycle after the final byte or empty marker.
// Throughput: one byte per cycle while ready; the parser state updates on each accepted byte.
// The verdict register decouples the sides: input stalls only while an unread verdict waits.
// Reset: arst_n clears the parser, the seen-key map, the byte count and the verdict register.
module tlv_settings_image_validator_unit #(
	parameter int IMAGE_CAPACITY = tlvv_pkg::DEFAULT_IMAGE_CAPACITY
) (
	input  logic clk,
	input  logic arst_n,
	tlvv_in_if.sink    image,
	tlvv_out_if.source result
);
	import tlvv_pkg::*;

	localparam int CNT_W = $clog2(IMAGE_CAPACITY + 2);

	st_t              st_q;
	st_t              st_n;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_n;
	err_t             code;
	logic             out_valid_q;
	err_t             error_code_q;
	logic             accept;
	logic             ends;

	tlvv_step #(
		.IMAGE_CAPACITY(IMAGE_CAPACITY),
		.CNT_W(CNT_W)
	) u_step (
		.st_q(st_q),
		.cnt_q(cnt_q),
		.data_byte(image.data_byte),
		.empty_image(image.empty_image),
		.st_n(st_n),
		.cnt_n(cnt_n),
		.code(code)
	);

	assign image.ready = !out_valid_q || result.ready;
	assign accept      = image.valid && image.ready;
	assign ends        = image.empty_image || image.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_CLEAR;
			cnt_q <= '0;
		end else if (accept) begin
			if (ends) begin
				st_q  <= ST_CLEAR;
				cnt_q <= '0;
			end else begin
				st_q  <= st_n;
				cnt_q <= cnt_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			error_code_q <= ERR_OK;
		end else if (accept && ends) begin
			out_valid_q  <= 1'b1;
			error_code_q <= code;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.image_valid = (error_code_q == ERR_OK);
	assign result.error_code  = error_code_q;

	// An image end must leave the parser and the seen map fully cleared.
	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ends |=> st_q == ST_CLEAR && cnt_q == '0)
		else $error("parser state not cleared after image end");

	// The value phase always has bytes still to come.
	a_value_left: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_VALUE |-> st_q.left != 16'd0)
		else $error("value phase with no bytes left");

	// Once an error is latched it stays until the image ends.
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.err != ERR_OK && !(accept && ends) |=> st_q.err == $past(st_q.err))
		else $error("latched error changed inside an image");

	// After an error only the count moves; the parser phase is frozen.
	a_phase_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.err != ERR_OK && !(accept && ends) |=> $stable(st_q.phase))
		else $error("parser advanced after an error");

	// An accepted final byte with a pending verdict means the verdict was taken that cycle.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ends && out_valid_q |-> result.ready)
		else $error("verdict overwritten before it was read");

endmodule
